>>> rtl/oale_pkg.sv
package oale_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;

  // Operation codes carried in the input transfer.
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEDUP   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DISPLAY = 3'd5;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_DROP,
    CELL_INSERT,
    CELL_DELETE,
    CELL_CLRFLAG
  } cell_op_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t            op;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   value;
    logic [IDX_W-1:0]    wrap;
    logic                mark;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_SCAN,
    S_MARK,
    S_PACK
  } state_t;

endpackage

>>> rtl/oale_cell.sv
module oale_cell import oale_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  index,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left_value,
  input  logic              left_flag,
  input  logic [DATA_W-1:0] right_value,
  input  logic              right_flag,
  input  logic [DATA_W-1:0] head_value,
  input  logic              head_flag,
  output logic [DATA_W-1:0] value,
  output logic              flag
);

  logic [DATA_W-1:0] value_next;
  logic              flag_next;
  logic [POS_W-1:0]  index_ext;

  assign index_ext = POS_W'(index);

  always_comb begin
    value_next = value;
    flag_next  = flag;
    unique case (cmd.op)
      CELL_HOLD: begin
      end
      CELL_ROTATE: begin
        // The ring closes at the last occupied cell, which takes the head.
        if (index == cmd.wrap) begin
          value_next = head_value;
          flag_next  = head_flag | cmd.mark;
        end else if (index < cmd.wrap) begin
          value_next = right_value;
          flag_next  = right_flag;
        end
      end
      CELL_DROP: begin
        value_next = right_value;
        flag_next  = right_flag;
      end
      CELL_INSERT: begin
        if (index_ext > cmd.pos) begin
          value_next = left_value;
          flag_next  = left_flag;
        end else if (index_ext == cmd.pos) begin
          value_next = cmd.value;
          flag_next  = 1'b0;
        end
      end
      CELL_DELETE: begin
        if (index_ext >= cmd.pos) begin
          value_next = right_value;
          flag_next  = right_flag;
        end
      end
      CELL_CLRFLAG: begin
        flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    flag  <= flag_next;
  end

endmodule

>>> rtl/oale_ctrl.sv
module oale_ctrl import oale_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,
  output logic              m_tlast,
  input  logic [DATA_W-1:0] head_value,
  input  logic              head_flag,
  output cell_cmd_t         cmd
);

  state_t state, state_next;

  logic [ACT_W-1:0]  in_action;
  logic [POS_W-1:0]  in_position;
  logic [DATA_W-1:0] in_value;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  n;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  i;
  logic [ACT_W-1:0]  act_q;
  logic [DATA_W-1:0] key;
  logic              key_valid;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [STAT_W-1:0] res_status;

  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_index;
  logic [DATA_W-1:0] out_value;
  logic [CNT_W-1:0]  out_count;
  logic              out_last;

  logic [STAT_W-1:0] load_status;
  logic [IDX_W-1:0]  load_index;
  logic [DATA_W-1:0] load_value;
  logic              load_last;
  logic              load_out;

  logic out_free;
  logic step_en;
  logic k_last;
  logic i_last;
  logic ins_ok;
  logic del_ok;
  logic accept;

  assign in_action   = s_tdata[2:0];
  assign in_position = s_tdata[9:3];
  assign in_value    = s_tdata[41:10];

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign k_last   = (CNT_W'(k) == n - CNT_W'(1));
  assign i_last   = (CNT_W'(i) == n - CNT_W'(1));
  assign ins_ok   = (in_position <= POS_W'(count)) && (count < CNT_W'(CAPACITY));
  assign del_ok   = (in_position < POS_W'(count));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_action) inside
            ACT_SEARCH, ACT_DISPLAY: state_next = (count == '0) ? S_EMIT : S_SCAN;
            ACT_DEDUP:               state_next = (count == '0) ? S_EMIT : S_MARK;
            default:                 state_next = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        if (step_en && k_last) begin
          state_next = (act_q == ACT_SEARCH) ? S_EMIT : S_IDLE;
        end
      end
      S_MARK: begin
        if (k_last && i_last) begin
          state_next = S_PACK;
        end
      end
      S_PACK: begin
        if (k_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = CELL_HOLD;
    cmd.pos     = in_position;
    cmd.value   = in_value;
    cmd.wrap    = IDX_W'(count - CNT_W'(1));
    cmd.mark    = 1'b0;
    s_tready    = 1'b0;
    step_en     = 1'b0;
    load_out    = 1'b0;
    load_status = res_status;
    load_index  = '0;
    load_value  = '0;
    load_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (in_action)
            ACT_INSERT: if (ins_ok) cmd.op = CELL_INSERT;
            ACT_DELETE: if (del_ok) cmd.op = CELL_DELETE;
            ACT_DEDUP:  if (count != '0) cmd.op = CELL_CLRFLAG;
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // A display step waits for room in the output register.
        step_en = (act_q == ACT_DISPLAY) ? out_free : 1'b1;
        if (step_en) begin
          cmd.op = CELL_ROTATE;
        end
        if (act_q == ACT_DISPLAY) begin
          load_out    = step_en;
          load_status = STAT_OK;
          load_index  = k;
          load_value  = head_value;
          load_last   = k_last;
        end
      end
      S_MARK: begin
        cmd.op   = CELL_ROTATE;
        cmd.mark = key_valid && (k > i) && (head_value == key);
      end
      S_PACK: begin
        cmd.op = head_flag ? CELL_DROP : CELL_ROTATE;
      end
      S_EMIT: begin
        load_out   = out_free;
        load_index = found ? found_idx : '0;
        load_value = found ? key : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        unique case (in_action)
          ACT_CLEAR:  count <= '0;
          ACT_INSERT: if (ins_ok) count <= count + CNT_W'(1);
          ACT_DELETE: if (del_ok) count <= count - CNT_W'(1);
          default: begin
          end
        endcase
      end else if (state == S_PACK && head_flag) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= load_status;
      out_index  <= load_index;
      out_value  <= load_value;
      out_count  <= count;
      out_last   <= load_last;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          act_q     <= in_action;
          n         <= count;
          k         <= '0;
          i         <= '0;
          key       <= in_value;
          key_valid <= 1'b0;
          found     <= 1'b0;
          unique case (in_action)
            ACT_CLEAR:   res_status <= STAT_OK;
            ACT_INSERT:  res_status <= ins_ok ? STAT_OK : STAT_INVALID;
            ACT_DELETE:  res_status <= del_ok ? STAT_OK : STAT_INVALID;
            ACT_SEARCH:  res_status <= STAT_NOTFOUND;
            ACT_DEDUP:   res_status <= (count == '0) ? STAT_EMPTY : STAT_OK;
            ACT_DISPLAY: res_status <= STAT_EMPTY;
            default:     res_status <= STAT_INVALID;
          endcase
        end
      end
      S_SCAN: begin
        if (step_en) begin
          k <= k + IDX_W'(1);
          if (act_q == ACT_SEARCH && !found && head_value == key) begin
            found      <= 1'b1;
            found_idx  <= k;
            res_status <= STAT_OK;
          end
        end
      end
      S_MARK: begin
        // Entry i becomes the key of this pass unless an earlier pass marked it.
        if (k == i) begin
          key       <= head_value;
          key_valid <= !head_flag;
        end
        if (k_last) begin
          k <= '0;
          i <= i + IDX_W'(1);
        end else begin
          k <= k + IDX_W'(1);
        end
      end
      S_PACK: begin
        k <= k + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {1'b0, out_count, out_value, out_index, out_status};
  assign m_tlast = out_last;

endmodule

>>> rtl/ordered_array_list_engine.sv
// Ordered list of up to 64 signed 32-bit entries held in a row of cells that
// can shift left, shift right or rotate as a ring closed at the last occupied
// entry. Clear, insert, delete and invalid requests are applied in the cycle
// of the input transfer, and their single result passes through the emit
// state into the output register. Search and display rotate the ring one entry
// per cycle, display only while there is room in the output register, through
// all count entries, and the ring ends in its original order; display loads
// one result per step, while search places its result from the emit state
// afterwards. Duplicate removal runs count marking passes that each rotate
// through all entries, then one compaction pass that drops marked entries.
// A new input transfer is accepted once the previous operation has placed
// its last result in the output register. There is no clearing pass after
// reset.
module ordered_array_list_engine import oale_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // action[2:0], position[9:3], item_value[41:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[1:0], found_index[7:2], entry_value[39:8],
                                 // entry_count[46:40]
  output logic        m_tlast
);

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_value [CAPACITY];
  logic              cell_flag  [CAPACITY];

  oale_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .head_value (cell_value[0]),
    .head_flag  (cell_flag[0]),
    .cmd        (cmd)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_value;
    logic              left_flag;
    logic [DATA_W-1:0] right_value;
    logic              right_flag;

    if (g == 0) begin : g_first
      assign left_value = '0;
      assign left_flag  = 1'b0;
    end else begin : g_inner_left
      assign left_value = cell_value[g-1];
      assign left_flag  = cell_flag[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_value = '0;
      assign right_flag  = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[g+1];
      assign right_flag  = cell_flag[g+1];
    end

    oale_cell u_cell (
      .clk         (clk),
      .index       (IDX_W'(g)),
      .cmd         (cmd),
      .left_value  (left_value),
      .left_flag   (left_flag),
      .right_value (right_value),
      .right_flag  (right_flag),
      .head_value  (cell_value[0]),
      .head_flag   (cell_flag[0]),
      .value       (cell_value[g]),
      .flag        (cell_flag[g])
    );
  end

endmodule

>>> rtl/oale_checker.sv
module oale_checker import oale_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result transfer keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[46:40] <= 7'(CAPACITY))
    else $error("entry count above capacity");

  // An empty-list result only comes from a list with no entries, as a single result.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == STAT_EMPTY |-> m_tdata[46:40] == '0 && m_tlast)
    else $error("empty status with entries or without last");

  // Only a display produces results that are not the last, and those are all ok.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[1:0] == STAT_OK)
    else $error("non-final result with error status");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:2] != '0 |-> 7'(m_tdata[7:2]) < m_tdata[46:40])
    else $error("reported index not below entry count");

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (.*);
